FILE: src/ahw_pkg.sv
package ahw_pkg;

    localparam int HARMONICS       = 16;
    localparam int TABLE_SIZE      = 2048;
    localparam int SINE_TABLE_BITS = 10;

    localparam int TABLE_BITS  = $clog2(TABLE_SIZE);
    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int QUARTER     = 1 << QUARTER_BITS;
    localparam int CNT_W       = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
    localparam int IDX_W       = 4;
    localparam int GAIN_W      = 16;
    localparam int PHASE_W     = 16;
    localparam int RATIO_W     = 16;
    localparam int RATIO_FRAC  = 8;
    localparam int N_W         = 11;
    localparam int SAMPLE_W    = 24;
    localparam int SINE_W      = 16;
    localparam int PROD_W      = GAIN_W + SINE_W;
    localparam int SHIFT       = 15;
    localparam int TERM_W      = PROD_W - SHIFT;
    localparam int ACC_W       = SAMPLE_W + $clog2(HARMONICS) + 2;

    typedef longint unsigned u64_t;

    localparam u64_t HALF_PI_Q30 = 64'd1686629713;

    // Taylor divisors (2k)(2k+1) for k = 1..7
    localparam u64_t TAYLOR_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                         64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [PHASE_W-1:0] phase;
        logic [RATIO_W-1:0] ratio;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic last;
    } op_t;

    typedef logic [SINE_W-2:0] qtab_t [QUARTER];

    function automatic logic [SINE_W-2:0] quarter_sine(u64_t r);
        u64_t   x;
        u64_t   x2;
        u64_t   t;
        u64_t   q;
        longint sum;
        x   = (r * HALF_PI_Q30) >> QUARTER_BITS;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / TAYLOR_DIV[k - 1];
            if ((k & 1) != 0) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (u64_t'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[SINE_W-2:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int i = 0; i < QUARTER; i++) begin
            tab[i] = quarter_sine(u64_t'(i));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();
    localparam logic [SINE_W-2:0] QPEAK = quarter_sine(u64_t'(QUARTER));

    // quarter-wave symmetry
    function automatic logic signed [SINE_W-1:0] sine_lookup(
        logic [SINE_TABLE_BITS-1:0] si
    );
        logic [1:0]              quad;
        logic [QUARTER_BITS-1:0] r;
        logic [QUARTER_BITS-1:0] mr;
        logic [SINE_W-2:0]       v;
        quad = si[SINE_TABLE_BITS-1 -: 2];
        r    = si[QUARTER_BITS-1:0];
        mr   = ~r + 1'b1;
        if (quad[0]) begin
            v = (r == '0) ? QPEAK : QTAB[mr];
        end else begin
            v = QTAB[r];
        end
        return quad[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

FILE: src/additive_harmonic_wavetable.sv
// channel | ports                                         | dir
// s_      | valid ready func harmonic_index gain           | in
//         | phase_offset ratio sample_index base_sample    |
// m_      | valid ready sample saturated                   | out
// A write item updates one cell and leaves the block ready. For a compute item,
// the harmonic entries rotate through the cell chain, one per cycle, into a
// shared 3-stage phase/sine/multiply unit, then the FINISH state saturates.
// Reset is synchronous; entries return to their defaults.
// A held result waits in the output register; the next item is taken meanwhile,
// and a following compute item holds in its saturate state until the register frees.
module additive_harmonic_wavetable (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [ahw_pkg::IDX_W-1:0]             s_harmonic_index,
    input  logic signed [ahw_pkg::GAIN_W-1:0]     s_gain,
    input  logic [ahw_pkg::PHASE_W-1:0]           s_phase_offset,
    input  logic [ahw_pkg::RATIO_W-1:0]           s_ratio,
    input  logic [ahw_pkg::N_W-1:0]               s_sample_index,
    input  logic signed [ahw_pkg::SAMPLE_W-1:0]   s_base_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ahw_pkg::SAMPLE_W-1:0]   m_sample,
    output logic                                  m_saturated
);
    import ahw_pkg::*;

    typedef enum logic [1:0] {IDLE, RUN, DRAIN, FINISH} state_t;

    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1 << (SAMPLE_W - 1));

    state_t                     state_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [N_W-1:0]             n_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_sample_reg;
    logic                       m_sat_reg;

    entry_t                     cell_q [HARMONICS];
    entry_t                     wr_data;
    logic                       accept;
    logic                       shift;
    op_t                        op_in;
    op_t                        op_out;
    logic signed [TERM_W-1:0]   term;
    logic                       out_free;

    assign s_ready  = (state_reg == IDLE);
    assign accept   = s_valid && s_ready;
    assign shift    = (state_reg == RUN);
    assign out_free = !m_valid_reg || m_ready;
    assign wr_data  = '{gain: s_gain, phase: s_phase_offset, ratio: s_ratio};

    assign op_in.valid = shift;
    assign op_in.last  = shift && (cnt_reg == CNT_W'(HARMONICS - 1));

    for (genvar h = 0; h < HARMONICS; h++) begin : g_cell
        entry_t init;
        logic   wr_en;
        assign init.gain  = (h == 0) ? GAIN_W'(16384) : '0;
        assign init.phase = '0;
        assign init.ratio = RATIO_W'((h + 1) * 256);
        assign wr_en = accept && !s_func && (int'(s_harmonic_index) == h);
        ahw_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .init      (init),
            .wr_en     (wr_en),
            .wr_data   (wr_data),
            .shift     (shift),
            .from_next (cell_q[(h == HARMONICS - 1) ? 0 : h + 1]),
            .q         (cell_q[h])
        );
    end

    ahw_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op_in   (op_in),
        .entry   (cell_q[0]),
        .n       (n_reg),
        .op_out  (op_out),
        .term    (term)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    cnt_reg <= '0;
                    if (accept && s_func) begin
                        n_reg     <= s_sample_index;
                        acc_reg   <= ACC_W'(s_base_sample);
                        state_reg <= RUN;
                    end
                end
                RUN: begin
                    if (op_in.last) begin
                        cnt_reg   <= '0;
                        state_reg <= DRAIN;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                DRAIN: begin
                    if (op_out.valid && op_out.last) begin
                        state_reg <= FINISH;
                    end
                end
                FINISH: begin
                    if (out_free) begin
                        if (acc_reg > OUT_MAX) begin
                            m_sample_reg <= OUT_MAX[SAMPLE_W-1:0];
                            m_sat_reg    <= 1'b1;
                        end else if (acc_reg < OUT_MIN) begin
                            m_sample_reg <= OUT_MIN[SAMPLE_W-1:0];
                            m_sat_reg    <= 1'b1;
                        end else begin
                            m_sample_reg <= acc_reg[SAMPLE_W-1:0];
                            m_sat_reg    <= 1'b0;
                        end
                        state_reg <= IDLE;
                    end
                end
                default: begin
                    state_reg <= IDLE;
                end
            endcase
            if (op_out.valid) begin
                acc_reg <= acc_reg + ACC_W'(term);
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sample    = m_sample_reg;
    assign m_saturated = m_sat_reg;

endmodule

FILE: src/ahw_cell.sv
module ahw_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  ahw_pkg::entry_t init,
    input  logic            wr_en,
    input  ahw_pkg::entry_t wr_data,
    input  logic            shift,
    input  ahw_pkg::entry_t from_next,
    output ahw_pkg::entry_t q
);
    import ahw_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (wr_en) begin
            entry_next = wr_data;
        end else if (shift) begin
            entry_next = from_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= init;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

FILE: src/ahw_unit.sv
module ahw_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ahw_pkg::op_t                        op_in,
    input  ahw_pkg::entry_t                     entry,
    input  logic [ahw_pkg::N_W-1:0]             n,
    output ahw_pkg::op_t                        op_out,
    output logic signed [ahw_pkg::TERM_W-1:0]   term
);
    import ahw_pkg::*;

    localparam int RN_W = RATIO_W + N_W;

    op_t                      op1_reg, op2_reg, op3_reg;
    logic [RN_W-1:0]          rn_reg;
    logic [PHASE_W-1:0]       off1_reg;
    logic signed [GAIN_W-1:0] gain1_reg, gain2_reg;
    logic signed [SINE_W-1:0] sine2_reg;
    logic signed [PROD_W-1:0] prod3_reg;

    logic [RN_W+RATIO_FRAC-1:0] scaled;
    logic [PHASE_W-1:0]         ph;

    assign scaled = {rn_reg, {RATIO_FRAC{1'b0}}} >> TABLE_BITS;
    assign ph     = scaled[PHASE_W-1:0] + off1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op1_reg <= '0;
            op2_reg <= '0;
            op3_reg <= '0;
        end else begin
            op1_reg <= op_in;
            op2_reg <= op1_reg;
            op3_reg <= op2_reg;
        end
        rn_reg    <= RN_W'(entry.ratio) * RN_W'(n);
        off1_reg  <= entry.phase;
        gain1_reg <= $signed(entry.gain);
        sine2_reg <= sine_lookup(ph[PHASE_W-1 -: SINE_TABLE_BITS]);
        gain2_reg <= gain1_reg;
        prod3_reg <= gain2_reg * sine2_reg;
    end

    assign op_out = op3_reg;
    assign term   = TERM_W'(prod3_reg >>> SHIFT);

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ahw_pkg::*;

    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_COMPUTE = 1'b1;
    localparam int   SINE_LEN     = 1 << SINE_TABLE_BITS;
    localparam int   QLEN         = SINE_LEN / 4;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    typedef struct {
        logic                       func;
        logic [IDX_W-1:0]           idx;
        logic signed [GAIN_W-1:0]   gain;
        logic [PHASE_W-1:0]         phase;
        logic [RATIO_W-1:0]         ratio;
        logic [N_W-1:0]             n;
        logic signed [SAMPLE_W-1:0] base;
        bit                         drain;
    } wt_item_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sat;
    } wt_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_func = 1'b0;
    logic [IDX_W-1:0] s_harmonic_index = '0;
    logic signed [GAIN_W-1:0] s_gain = '0;
    logic [PHASE_W-1:0] s_phase_offset = '0;
    logic [RATIO_W-1:0] s_ratio = '0;
    logic [N_W-1:0] s_sample_index = '0;
    logic signed [SAMPLE_W-1:0] s_base_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample;
    logic m_saturated;

    additive_harmonic_wavetable uut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    wt_item_t   pending_items[$];
    wt_result_t expected_samples[$];
    int         sine_tab[SINE_LEN];
    logic signed [GAIN_W-1:0] tbl_gain[HARMONICS];
    logic [PHASE_W-1:0]       tbl_phase[HARMONICS];
    logic [RATIO_W-1:0]       tbl_ratio[HARMONICS];
    int errors = 0, n_writes = 0, n_computes = 0, n_sat = 0, n_checked = 0;

    function automatic int quarter_wave(longint unsigned r);
        longint unsigned x, x2, t, q;
        longint sum;
        x = (r * PI_HALF_Q30) / QLEN;
        x2 = (x * x) >> 30;
        t = x;
        sum = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum = sum - longint'(t);
            else sum = sum + longint'(t);
        end
        if (sum < 0) sum = 0;
        q = (u64_t'(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) q = 64'd32767;
        return int'(q);
    endfunction

    task automatic reset_harmonics();
        for (int i = 0; i < SINE_LEN; i++) begin
            int quad, r, v;
            quad = i / QLEN;
            r = i % QLEN;
            v = (quad % 2 == 1) ? quarter_wave(QLEN - r) : quarter_wave(r);
            sine_tab[i] = (quad >= 2) ? -v : v;
        end
        for (int h = 0; h < HARMONICS; h++) begin
            tbl_gain[h] = (h == 0) ? 16'sd16384 : 16'sd0;
            tbl_phase[h] = '0;
            tbl_ratio[h] = RATIO_W'((h + 1) * 256);
        end
    endtask

    task automatic apply_item(wt_item_t it);
        longint acc, p, prod;
        int ph, si;
        wt_result_t res;
        if (it.func == FUNC_WRITE) begin
            n_writes++;
            if (it.idx < HARMONICS) begin
                tbl_gain[it.idx] = it.gain;
                tbl_phase[it.idx] = it.phase;
                tbl_ratio[it.idx] = it.ratio;
            end
        end else begin
            n_computes++;
            acc = longint'(it.base);
            for (int h = 0; h < HARMONICS; h++) begin
                p = (longint'(tbl_ratio[h]) * longint'(it.n) * 256) / TABLE_SIZE;
                ph = int'((p + longint'(tbl_phase[h])) % 65536);
                si = ph >> (16 - SINE_TABLE_BITS);
                prod = longint'(tbl_gain[h]) * longint'(sine_tab[si]);
                acc += prod >>> SHIFT;
            end
            res.sat = 1'b0;
            if (acc > 8388607) begin
                acc = 8388607;
                res.sat = 1'b1;
            end else if (acc < -8388608) begin
                acc = -8388608;
                res.sat = 1'b1;
            end
            if (res.sat) n_sat++;
            res.sample = SAMPLE_W'(acc);
            expected_samples.insert(expected_samples.size(), res);
        end
    endtask

    function automatic wt_item_t mk_write(int idx, int g, int ph, int r);
        wt_item_t it;
        it = '{default: '0};
        it.func = FUNC_WRITE;
        it.idx = IDX_W'(idx);
        it.gain = GAIN_W'(g);
        it.phase = PHASE_W'(ph);
        it.ratio = RATIO_W'(r);
        it.n = N_W'($urandom);
        it.base = SAMPLE_W'($urandom);
        return it;
    endfunction

    function automatic wt_item_t mk_compute(int n, int base);
        wt_item_t it;
        it = '{default: '0};
        it.func = FUNC_COMPUTE;
        it.n = N_W'(n);
        it.base = SAMPLE_W'(base);
        it.idx = IDX_W'($urandom);
        it.gain = GAIN_W'($urandom);
        it.phase = PHASE_W'($urandom);
        it.ratio = RATIO_W'($urandom);
        return it;
    endfunction

    // driver: bursts with random gaps
    wt_item_t cur;
    logic nv;
    int gap = 0, burst = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                apply_item(cur);
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap > 0) begin
                    gap--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && expected_samples.size() != 0)) begin
                    cur = pending_items.pop_front();
                    s_func <= cur.func;
                    s_harmonic_index <= cur.idx;
                    s_gain <= cur.gain;
                    s_phase_offset <= cur.phase;
                    s_ratio <= cur.ratio;
                    s_sample_index <= cur.n;
                    s_base_sample <= cur.base;
                    nv = 1'b1;
                    if (burst == 0) begin
                        burst = $urandom_range(1, 30);
                        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 25);
                    end else begin
                        burst--;
                    end
                end
            end
            s_valid <= nv;
        end
    end

    // monitor: receiver stalls in modes
    int stall_mode = 0, mode_left = 0;
    wt_result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected item sample=%0d sat=%0b",
                         $time, m_sample, m_saturated);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                n_checked++;
                if (m_sample !== want.sample) begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, want.sample, m_sample);
                    errors++;
                end
                if (m_saturated !== want.sat) begin
                    $display("%0t: saturated expected %0b actual %0b",
                             $time, want.sat, m_saturated);
                    errors++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 1) != 0);
            default: m_ready <= ($urandom_range(0, 40) == 0);
        endcase
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        wt_item_t it;
        reset_harmonics();
        pending_items.insert(pending_items.size(), mk_compute(0, 0));
        pending_items.insert(pending_items.size(), mk_compute(512, 8388607));
        pending_items.insert(pending_items.size(), mk_compute(1536, -8388608));
        pending_items.insert(pending_items.size(), mk_compute(2047, 0));
        for (int h = 0; h < HARMONICS; h++)
            pending_items.insert(pending_items.size(),
                                 mk_write(h, (h % 2) ? -32768 : 32767,
                                          (h % 3) ? 65535 : 0, (h % 2) ? 65535 : 0));
        pending_items.insert(pending_items.size(), mk_compute(0, 8388607));
        pending_items.insert(pending_items.size(), mk_compute(1, -8388608));
        pending_items.insert(pending_items.size(), mk_compute(1024, 0));
        it = mk_compute(777, 123);
        it.drain = 1'b1;
        pending_items.insert(pending_items.size(), it);
        for (int i = 0; i < 1500; i++) begin
            if ($urandom_range(0, 9) < 3)
                it = mk_write($urandom_range(0, 15), $urandom, $urandom, $urandom);
            else
                it = mk_compute($urandom_range(0, 2047),
                                ($urandom_range(0, 4) == 0) ?
                                (($urandom_range(0, 1) != 0) ? 8388607 : -8388608) : $urandom);
            it.drain = ($urandom_range(0, 299) == 0);
            pending_items.insert(pending_items.size(), it);
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_items.size() == 0 && !s_valid && expected_samples.size() == 0);
        repeat (60) @(posedge aclk);
        if (expected_samples.size() != 0) begin
            $display("%0t: %0d expected items never came", $time, expected_samples.size());
            errors++;
        end
        $display("Ran %0d harmonic writes and %0d sample computes (%0d saturated),",
                 n_writes, n_computes, n_sat);
        $display("with bursty input, varied output stalls and a full drain; %0d checked.",
                 n_checked);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
